// ===== hdl/sbda_pkg.sv =====
// Shared types and constants for the signed binary to decimal ASCII unit.
package sbda_pkg;

   localparam int VALUE_WIDTH     = 64;
   localparam int CHAR_WIDTH      = 6;
   localparam int NUM_DIGITS      = 20;
   localparam int DIGIT_WIDTH     = 4;
   localparam int DIGIT_IDX_WIDTH = 5;
   localparam int BIT_CNT_WIDTH   = 6;

   localparam logic [DIGIT_IDX_WIDTH-1:0] TOP_DIGIT_IDX = DIGIT_IDX_WIDTH'(NUM_DIGITS - 1);
   localparam logic [BIT_CNT_WIDTH-1:0]   LAST_BIT_CNT  = BIT_CNT_WIDTH'(VALUE_WIDTH - 1);

   localparam logic [CHAR_WIDTH-1:0]  CHAR_ZERO  = 6'd48;
   localparam logic [CHAR_WIDTH-1:0]  CHAR_MINUS = 6'd45;
   localparam logic [DIGIT_WIDTH-1:0] DIGIT_FIVE = 4'd5;
   localparam logic [DIGIT_WIDTH-1:0] DIGIT_ADJ  = 4'd3;

   typedef logic [NUM_DIGITS-1:0][DIGIT_WIDTH-1:0] bcd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SKIP,
      ST_SIGN,
      ST_DIGIT
   } emit_state_type;

   typedef struct packed {
      logic done;
      logic negative;
   } conv_type;

endpackage

// ===== hdl/sbda_if.sv =====
// Valid/ready channel interfaces for the number words and the character words.
interface sbda_req_if;
   logic                                     valid;
   logic                                     ready;
   logic signed [sbda_pkg::VALUE_WIDTH-1:0]  value;

   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

interface sbda_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [sbda_pkg::CHAR_WIDTH-1:0]   char_code;
   logic                              last;

   modport source (output valid, output char_code, output last, input ready);
   modport sink (input valid, input char_code, input last, output ready);
endinterface

// ===== hdl/sbda_dabble.sv =====
// Shift-and-add-three binary to BCD converter, one magnitude bit per cycle.
module sbda_dabble (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [sbda_pkg::VALUE_WIDTH-1:0]  magnitude,
   output logic                              done,
   output sbda_pkg::bcd_type                 digits
);
   import sbda_pkg::*;

   logic [VALUE_WIDTH-1:0]   bin_ff, bin_in;
   bcd_type                  bcd_ff, bcd_in;
   bcd_type                  adjusted;
   logic [NUM_DIGITS*DIGIT_WIDTH-1:0] adjusted_bits;
   logic [BIT_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;

   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd_ff[i] >= DIGIT_FIVE) begin
            adjusted[i] = bcd_ff[i] + DIGIT_ADJ;
         end else begin
            adjusted[i] = bcd_ff[i];
         end
      end
   end

   assign adjusted_bits = adjusted;

   always_comb begin
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         bin_in  = magnitude;
         bcd_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         bin_in = {bin_ff[VALUE_WIDTH-2:0], 1'b0};
         bcd_in = {adjusted_bits[NUM_DIGITS*DIGIT_WIDTH-2:0], bin_ff[VALUE_WIDTH-1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_BIT_CNT) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign done   = done_ff;
   assign digits = bcd_ff;

endmodule

// ===== hdl/sbda_emit.sv =====
// Character sequencer that drops leading zeros and drives the output word register.
module sbda_emit (
   input  logic               clock,
   input  logic               reset,
   input  sbda_pkg::conv_type conv,
   input  sbda_pkg::bcd_type  digits,
   output logic               finished,
   sbda_rsp_if.source         rsp_chan
);
   import sbda_pkg::*;

   emit_state_type             state_ff, state_in;
   logic [DIGIT_IDX_WIDTH-1:0] idx_ff, idx_in;
   bcd_type                    digits_ff, digits_in;
   logic                       neg_ff, neg_in;
   logic                       valid_ff, valid_in;
   logic [CHAR_WIDTH-1:0]      char_ff, char_in;
   logic                       last_ff, last_in;

   logic [DIGIT_WIDTH-1:0]     cur_digit;
   logic                       out_free;
   logic                       at_zero_idx;

   assign cur_digit   = digits_ff[idx_ff];
   assign out_free    = !valid_ff || rsp_chan.ready;
   assign at_zero_idx = (idx_ff == '0);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (conv.done) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (cur_digit != '0 || at_zero_idx) begin
               state_in = neg_ff ? ST_SIGN : ST_DIGIT;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               state_in = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (out_free && at_zero_idx) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      idx_in    = idx_ff;
      digits_in = digits_ff;
      neg_in    = neg_ff;
      valid_in  = valid_ff && !rsp_chan.ready;
      char_in   = char_ff;
      last_in   = last_ff;
      finished  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (conv.done) begin
               digits_in = digits;
               neg_in    = conv.negative;
               idx_in    = TOP_DIGIT_IDX;
            end
         end
         ST_SKIP: begin
            if (cur_digit == '0 && !at_zero_idx) begin
               idx_in = idx_ff - 1'b1;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               valid_in = 1'b1;
               char_in  = CHAR_MINUS;
               last_in  = 1'b0;
            end
         end
         ST_DIGIT: begin
            if (out_free) begin
               valid_in = 1'b1;
               char_in  = CHAR_ZERO + {{(CHAR_WIDTH-DIGIT_WIDTH){1'b0}}, cur_digit};
               last_in  = at_zero_idx;
               if (at_zero_idx) begin
                  finished = 1'b1;
               end else begin
                  idx_in = idx_ff - 1'b1;
               end
            end
         end
         default: begin
            valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      idx_ff    <= idx_in;
      digits_ff <= digits_in;
      neg_ff    <= neg_in;
      char_ff   <= char_in;
      last_ff   <= last_in;
   end

   assign rsp_chan.valid     = valid_ff;
   assign rsp_chan.char_code = char_ff;
   assign rsp_chan.last      = last_ff;

endmodule

// ===== hdl/signed_binary_to_decimal_ascii_unit.sv =====
// Top level: signed 64-bit number in, decimal ASCII text out, one character per word.
// After acceptance the magnitude runs through the shift-and-add-three unit, then the emitter
// skips the leading zero digits (1 to 19). Characters then leave one per cycle while the
// sink is ready. A new number is taken only once the last character of the previous one has
// been emitted; req ready is low for the whole conversion.
// Reset is synchronous and active high; it clears the control state and drops rsp valid.
module signed_binary_to_decimal_ascii_unit (
   input  logic       clock,
   input  logic       reset,
   sbda_req_if.sink   req_chan,
   sbda_rsp_if.source rsp_chan
);
   import sbda_pkg::*;

   logic                   busy_ff, busy_in;
   logic                   neg_ff, neg_in;
   logic                   accept;
   logic                   negative;
   logic [VALUE_WIDTH-1:0] magnitude;
   logic                   dabble_done;
   bcd_type                digits;
   conv_type               conv;
   logic                   finished;

   assign accept    = req_chan.valid && req_chan.ready;
   assign negative  = req_chan.value[VALUE_WIDTH-1];
   assign magnitude = negative ? (~req_chan.value + 1'b1) : req_chan.value;

   always_comb begin
      busy_in = busy_ff;
      neg_in  = neg_ff;
      if (accept) begin
         busy_in = 1'b1;
         neg_in  = negative;
      end else if (finished) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      neg_ff <= neg_in;
   end

   assign req_chan.ready = !busy_ff;
   assign conv.done      = dabble_done;
   assign conv.negative  = neg_ff;

   sbda_dabble u_dabble (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .magnitude (magnitude),
      .done      (dabble_done),
      .digits    (digits)
   );

   sbda_emit u_emit (
      .clock    (clock),
      .reset    (reset),
      .conv     (conv),
      .digits   (digits),
      .finished (finished),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== test/testbench.sv =====
// Testbench for the signed binary to decimal ASCII unit: directed table, random numbers, text check.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import sbda_pkg::*;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] char_code;
      logic                  last;
   } char_word;

   typedef struct {
      logic signed [VALUE_WIDTH-1:0] value;
      string                         text;
   } number_row;

   localparam int NUM_ROWS      = 20;
   localparam int RANDOM_ITEMS  = 400;
   localparam int HOLD_CYCLES   = 500;
   localparam int SETTLE_CYCLES = 120;

   logic clock = 1'b0;
   logic reset;

   sbda_req_if req_chan ();
   sbda_rsp_if rsp_chan ();

   signed_binary_to_decimal_ascii_unit DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   char_word    expected_chars[$];
   number_row   number_table[NUM_ROWS];
   int unsigned mismatch_count = 0;
   int unsigned numbers_sent = 0;
   int unsigned negatives_sent = 0;
   int unsigned chars_checked = 0;
   int unsigned long_holds = 0;
   int unsigned burst_left = 0;
   bit          sender_active = 1'b0;
   bit          long_hold_request = 1'b0;

   always #5 clock = ~clock;

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatch_count++;
   endtask

   function automatic void push_text(input string text);
      char_word word;
      for (int i = 0; i < text.len(); i++) begin
         word.char_code = CHAR_WIDTH'(text[i]);
         word.last      = (i == text.len() - 1);
         expected_chars.push_back(word);
      end
   endfunction

   function automatic void predict_text(input logic signed [VALUE_WIDTH-1:0] number);
      logic [VALUE_WIDTH-1:0] magnitude;
      logic [DIGIT_WIDTH-1:0] digits[NUM_DIGITS];
      int                     count;
      int                     total;
      int                     k;
      bit                     negative;
      char_word               word;
      negative  = number[VALUE_WIDTH-1];
      magnitude = negative ? (64'd0 - number) : number;
      count     = 0;
      do begin
         digits[count] = DIGIT_WIDTH'(magnitude % 10);
         magnitude     = magnitude / 10;
         count++;
      end while (magnitude != 0 && count < NUM_DIGITS);
      total = count + (negative ? 1 : 0);
      k     = 0;
      if (negative) begin
         word.char_code = CHAR_MINUS;
         word.last      = (k == total - 1);
         expected_chars.push_back(word);
         k++;
      end
      for (int i = count - 1; i >= 0; i--) begin
         word.char_code = CHAR_ZERO + CHAR_WIDTH'(digits[i]);
         word.last      = (k == total - 1);
         expected_chars.push_back(word);
         k++;
      end
   endfunction

   function automatic logic signed [VALUE_WIDTH-1:0] random_number();
      logic [VALUE_WIDTH-1:0] raw;
      logic [VALUE_WIDTH-1:0] power;
      int unsigned            width;
      raw   = {$urandom, $urandom};
      power = 64'd1;
      case ($urandom_range(0, 9))
         0, 1, 2: begin
         end
         3, 4: begin
            width = $urandom_range(1, 63);
            raw   = raw & ((64'd1 << width) - 64'd1);
            if ($urandom_range(0, 1) == 1) raw = 64'd0 - raw;
         end
         5, 6: begin
            raw = 64'($urandom_range(0, 1000));
            if ($urandom_range(0, 1) == 1) raw = 64'd0 - raw;
         end
         7, 8: begin
            repeat ($urandom_range(0, 18)) power = power * 10;
            raw = power - 64'($urandom_range(0, 1));
            if ($urandom_range(0, 1) == 1) raw = 64'd0 - raw;
         end
         default: begin
            case ($urandom_range(0, 3))
               0: raw = 64'h8000_0000_0000_0000;
               1: raw = 64'h7FFF_FFFF_FFFF_FFFF;
               2: raw = 64'd0;
               default: raw = '1;
            endcase
         end
      endcase
      return raw;
   endfunction

   task automatic offer_number(input logic signed [VALUE_WIDTH-1:0] number, input string text,
                               input bit ask_hold);
      req_chan.value <= number;
      req_chan.valid <= 1'b1;
      sender_active = 1'b1;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      if (text.len() != 0) push_text(text);
      else predict_text(number);
      numbers_sent++;
      if (number[VALUE_WIDTH-1]) negatives_sent++;
      if (ask_hold) long_hold_request = 1'b1;
      @(negedge clock);
      if (burst_left == 0) begin
         req_chan.valid <= 1'b0;
         sender_active = 1'b0;
         if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 100)) @(negedge clock);
         else repeat ($urandom_range(1, 4)) @(negedge clock);
         burst_left = $urandom_range(0, 7);
      end else begin
         burst_left--;
      end
   endtask

   task automatic wait_for_drain();
      if (sender_active) begin
         req_chan.valid <= 1'b0;
         sender_active = 1'b0;
      end
      burst_left = 0;
      do @(negedge clock); while (expected_chars.size() != 0);
   endtask

   task automatic check_char_word();
      char_word want;
      if (expected_chars.size() == 0) begin
         report_mismatch($sformatf("character word %0d last %0b with nothing expected",
                                   rsp_chan.char_code, rsp_chan.last));
      end else begin
         want = expected_chars.pop_front();
         chars_checked++;
         if (rsp_chan.char_code !== want.char_code)
            report_mismatch($sformatf("char_code %0d, expected %0d",
                                      rsp_chan.char_code, want.char_code));
         if (rsp_chan.last !== want.last)
            report_mismatch($sformatf("last %0b, expected %0b (char_code %0d)",
                                      rsp_chan.last, want.last, want.char_code));
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) check_char_word();
   end

   initial begin : char_sink
      int unsigned mode;
      int unsigned mode_left;
      int unsigned hold_left;
      int unsigned phase;
      rsp_chan.ready = 1'b0;
      mode      = 0;
      mode_left = 0;
      hold_left = 0;
      phase     = 0;
      forever begin
         @(negedge clock);
         if (long_hold_request) begin
            hold_left         = HOLD_CYCLES;
            long_hold_request = 1'b0;
            long_holds++;
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 300);
         end else begin
            mode_left--;
         end
         phase++;
         if (hold_left != 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            case (mode)
               0: rsp_chan.ready <= 1'b1;
               1: rsp_chan.ready <= ($urandom_range(0, 1) == 1);
               2: rsp_chan.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_chan.ready <= (phase % 2 == 0);
            endcase
         end
      end
   end

   initial begin
      #10_000_000;
      $display("timeout with %0d character words still expected", expected_chars.size());
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      reset          = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.value = '0;
      number_table = '{
         '{64'sd0, "0"},
         '{64'sd1, "1"},
         '{-64'sd1, "-1"},
         '{64'sd9, "9"},
         '{-64'sd9, "-9"},
         '{64'sd10, "10"},
         '{-64'sd10, "-10"},
         '{64'sh7FFF_FFFF_FFFF_FFFF, "9223372036854775807"},
         '{64'sh8000_0000_0000_0000, "-9223372036854775808"},
         '{64'sh8000_0000_0000_0001, "-9223372036854775807"},
         '{64'sd1000000000000000000, "1000000000000000000"},
         '{64'sd999999999999999999, ""},
         '{-64'sd999999999999999999, ""},
         '{64'sd100, ""},
         '{64'sd2, ""},
         '{64'sd12345, ""},
         '{64'shAAAA_AAAA_AAAA_AAAA, ""},
         '{64'sh5555_5555_5555_5555, ""},
         '{64'shFFFF_FFFF_0000_0000, ""},
         '{64'sh0000_0000_FFFF_FFFF, ""}
      };
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (number_table[i]) offer_number(number_table[i].value, number_table[i].text, 1'b0);
      wait_for_drain();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         offer_number(random_number(), "", (n == 100 || n == 320));
         if (n == 250) wait_for_drain();
      end
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (expected_chars.size() != 0)
         report_mismatch($sformatf("%0d character words never arrived", expected_chars.size()));
      $display("covered %0d numbers (%0d negative) and %0d character words checked",
               numbers_sent, negatives_sent, chars_checked);
      $display("receiver held off %0d times for %0d cycles, sender drained twice mid-run",
               long_holds, HOLD_CYCLES);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
